// ----- design/radio_ping_pong_link_tester_core_assert.svh -----
// ----------------------------------------------------------------------------
// radio_ping_pong_link_tester_core_assert.svh
// assertion macros shared by the link tester rtl
// ----------------------------------------------------------------------------
`ifndef RADIO_PING_PONG_LINK_TESTER_CORE_ASSERT_SVH
`define RADIO_PING_PONG_LINK_TESTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define RPPLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RPPLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rpplt_pkg.sv -----
// ----------------------------------------------------------------------------
// rpplt_pkg
// types and constants of the ping-pong link tester
// ----------------------------------------------------------------------------
`default_nettype none

package rpplt_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PING_PERIOD = 2'd0,
      CSR_PONG_DELAY  = 2'd1,
      CSR_GUARD       = 2'd2,
      CSR_SETUP_OK    = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   // configuration reset values
   localparam logic [15:0] PING_PERIOD_RST = 16'd1000;
   localparam logic [15:0] PONG_DELAY_RST  = 16'd400;
   localparam logic [7:0]  GUARD_RST       = 8'd5;
   localparam logic        SETUP_OK_RST    = 1'b1;

   // protocol states
   typedef enum logic [3:0] {
      ST_INIT            = 4'd0,
      ST_M_SEND_PING     = 4'd1,
      ST_M_PING_DONE     = 4'd2,
      ST_M_START_RX_PONG = 4'd3,
      ST_M_RX_PONG       = 4'd4,
      ST_S_START_RX_PING = 4'd5,
      ST_S_RX_PING       = 4'd6,
      ST_S_SEND_PONG     = 4'd7,
      ST_S_PONG_DONE     = 4'd8,
      ST_ERROR           = 4'd9
   } state_type;

   // radio commands
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_CONFIGURE = 3'd1,
      CMD_PING      = 3'd2,
      CMD_PONG      = 3'd3,
      CMD_RECEIVE   = 3'd4,
      CMD_STANDBY   = 3'd5
   } cmd_type;

   // indicator pulses
   typedef enum logic [1:0] {
      IND_NONE  = 2'd0,
      IND_TX    = 2'd1,
      IND_RX_OK = 2'd2
   } ind_type;

   // item operations and payload classes
   localparam logic       OP_POLL   = 1'b0;
   localparam logic       OP_STOP   = 1'b1;
   localparam logic [1:0] KIND_PING = 2'd0;
   localparam logic [1:0] KIND_PONG = 2'd1;

   localparam logic ROLE_MASTER = 1'b0;
   localparam logic ROLE_SLAVE  = 1'b1;

   typedef struct packed {
      logic [15:0] ping_period;
      logic [15:0] pong_delay;
      logic [7:0]  guard;
      logic        setup_ok;
   } cfg_type;

   typedef struct packed {
      logic               operation;
      logic [31:0]        now_ms;
      logic               irq_pending;
      logic [31:0]        irq_time_ms;
      logic               flag_tx_done;
      logic               flag_rx_done;
      logic               flag_rx_timeout;
      logic               flag_crc_error;
      logic [1:0]         payload_kind;
      logic signed [7:0]  rssi_dbm;
   } item_type;

   typedef struct packed {
      state_type          state;
      logic               role;
      logic [31:0]        tx_instant;
      logic [31:0]        rx_instant;
      logic [31:0]        tx_cnt;
      logic [31:0]        ok_cnt;
      logic [31:0]        wrong_cnt;
      logic [31:0]        to_cnt;
      logic signed [7:0]  rssi;
   } ctx_type;

   typedef struct packed {
      cmd_type  cmd;
      logic     clear_irq;
      ind_type  indicator;
      logic     fetch_stats;
   } act_type;

endpackage

`default_nettype wire

// ----- design/rpplt_csr.sv -----
// ----------------------------------------------------------------------------
// rpplt_csr
// configuration registers of the link tester
// ----------------------------------------------------------------------------
`default_nettype none

module rpplt_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [rpplt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rpplt_pkg::cfg_type                 cfg
);
   import rpplt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PING_PERIOD: cfg_in.ping_period = csr_wdata;
            CSR_PONG_DELAY:  cfg_in.pong_delay  = csr_wdata;
            CSR_GUARD:       cfg_in.guard       = csr_wdata[7:0];
            CSR_SETUP_OK:    cfg_in.setup_ok    = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_period <= PING_PERIOD_RST;
         cfg_ff.pong_delay  <= PONG_DELAY_RST;
         cfg_ff.guard       <= GUARD_RST;
         cfg_ff.setup_ok    <= SETUP_OK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/rpplt_step.sv -----
// ----------------------------------------------------------------------------
// rpplt_step
// one protocol step: next state, radio actions and context update
// ----------------------------------------------------------------------------
`default_nettype none

module rpplt_step (
   input  wire rpplt_pkg::cfg_type  cfg,
   input  wire rpplt_pkg::item_type item,
   input  wire rpplt_pkg::ctx_type  ctx_cur,
   output rpplt_pkg::ctx_type  ctx_nxt,
   output rpplt_pkg::act_type  act
);
   import rpplt_pkg::*;

   logic [15:0] ping_win;
   logic [15:0] pong_win;
   logic [31:0] since_tx;
   logic [31:0] since_rx;
   logic [31:0] rx_anchor;
   logic        ping_due;
   logic        pong_rx_due;
   logic        pong_wait_over;
   logic        ping_wait_over;
   logic        slave_wait_over;
   logic        pong_due;
   logic        is_stop;
   logic        rx_good;
   logic        tx_irq;
   logic        is_ping;
   logic        is_pong;
   cmd_type     send_cmd;
   state_type   state_in;
   logic        inc_tx;
   logic        inc_ok;
   logic        inc_wrong;
   logic [1:0]  inc_to;

   // receive windows, period or delay minus guard saturating at zero
   assign ping_win = (cfg.ping_period > {8'd0, cfg.guard}) ?
                     (cfg.ping_period - {8'd0, cfg.guard}) : 16'd0;
   assign pong_win = (cfg.pong_delay > {8'd0, cfg.guard}) ?
                     (cfg.pong_delay - {8'd0, cfg.guard}) : 16'd0;

   // elapsed times, modulo 2^32
   assign since_tx = item.now_ms - ctx_cur.tx_instant;
   assign since_rx = item.now_ms - ctx_cur.rx_instant;

   // slave give-up window runs from the rx instant as this step leaves it
   assign rx_anchor = (rx_good && is_ping) ? item.irq_time_ms : ctx_cur.rx_instant;

   assign ping_due        = since_tx > {16'd0, cfg.ping_period};
   assign pong_rx_due     = since_tx > {16'd0, pong_win};
   assign pong_wait_over  = since_tx > {16'd0, ping_win};
   assign ping_wait_over  = since_rx > {16'd0, ping_win};
   assign slave_wait_over = (item.now_ms - rx_anchor) > {15'd0, ping_win, 1'b0};
   assign pong_due        = since_rx > {16'd0, cfg.pong_delay};

   // item decode
   assign is_stop  = item.operation == OP_STOP;
   assign rx_good  = item.irq_pending && item.flag_rx_done && !item.flag_crc_error;
   assign tx_irq   = item.irq_pending && item.flag_tx_done;
   assign is_ping  = item.payload_kind == KIND_PING;
   assign is_pong  = item.payload_kind == KIND_PONG;
   assign send_cmd = ctx_cur.role ? CMD_PONG : CMD_PING;

   // next protocol state
   always_comb begin
      state_in = ctx_cur.state;
      if (is_stop) begin
         state_in = ST_INIT;
      end else begin
         case (ctx_cur.state)
            ST_INIT: begin
               state_in = cfg.setup_ok ? ST_M_SEND_PING : ST_ERROR;
            end
            ST_M_SEND_PING: begin
               if (ping_due) state_in = ST_M_PING_DONE;
            end
            ST_M_PING_DONE: begin
               if (tx_irq) state_in = ST_M_RX_PONG;
            end
            ST_M_START_RX_PONG: begin
               if (pong_rx_due) state_in = ST_M_RX_PONG;
            end
            ST_M_RX_PONG: begin
               if (item.irq_pending) begin
                  if (rx_good) begin
                     state_in = is_ping ? ST_S_SEND_PONG : ST_M_SEND_PING;
                  end
                  if (item.flag_rx_timeout) state_in = ST_M_SEND_PING;
               end else if (pong_wait_over) begin
                  state_in = ST_M_SEND_PING;
               end
            end
            ST_S_START_RX_PING: begin
               if (ping_wait_over) state_in = ST_S_RX_PING;
            end
            ST_S_RX_PING: begin
               if (rx_good && is_ping) state_in = ST_S_SEND_PONG;
               if (rx_good && is_pong) state_in = ST_M_SEND_PING;
               if (item.irq_pending && item.flag_rx_timeout) state_in = ST_M_SEND_PING;
               if (slave_wait_over) state_in = ST_M_SEND_PING;
            end
            ST_S_SEND_PONG: begin
               if (pong_due) state_in = ST_S_PONG_DONE;
            end
            ST_S_PONG_DONE: begin
               if (tx_irq) state_in = ST_S_RX_PING;
            end
            default: state_in = ctx_cur.state;
         endcase
      end
   end

   // radio actions of the step
   always_comb begin
      act = '{cmd: CMD_NONE, clear_irq: 1'b0, indicator: IND_NONE, fetch_stats: 1'b0};
      if (is_stop) begin
         act.cmd = CMD_STANDBY;
      end else begin
         case (ctx_cur.state)
            ST_INIT: act.cmd = CMD_CONFIGURE;
            ST_M_SEND_PING, ST_S_SEND_PONG: begin
               if ((ctx_cur.state == ST_M_SEND_PING) ? ping_due : pong_due) begin
                  act.cmd       = send_cmd;
                  act.indicator = IND_TX;
               end
            end
            ST_M_PING_DONE: begin
               act.clear_irq = item.irq_pending;
               if (tx_irq) begin
                  act.fetch_stats = 1'b1;
                  act.cmd         = CMD_RECEIVE;
               end
            end
            ST_M_START_RX_PONG: begin
               if (pong_rx_due) act.cmd = CMD_RECEIVE;
            end
            ST_M_RX_PONG: begin
               act.clear_irq = item.irq_pending;
               if (rx_good && is_pong) act.indicator = IND_RX_OK;
               if (!item.irq_pending && pong_wait_over) act.cmd = CMD_STANDBY;
            end
            ST_S_START_RX_PING: begin
               if (ping_wait_over) act.cmd = CMD_RECEIVE;
            end
            ST_S_RX_PING: begin
               act.clear_irq = item.irq_pending;
               if (rx_good && is_ping) act.indicator = IND_RX_OK;
               if (slave_wait_over) act.cmd = CMD_STANDBY;
            end
            ST_S_PONG_DONE: begin
               if (tx_irq) begin
                  act.clear_irq   = 1'b1;
                  act.fetch_stats = 1'b1;
                  act.cmd         = CMD_RECEIVE;
               end
            end
            default: act.cmd = CMD_NONE;
         endcase
      end
   end

   // counter increments, instants, role and rssi
   always_comb begin
      inc_tx    = 1'b0;
      inc_ok    = 1'b0;
      inc_wrong = 1'b0;
      inc_to    = 2'd0;
      ctx_nxt   = ctx_cur;
      if (!is_stop) begin
         case (ctx_cur.state)
            ST_INIT: begin
               if (cfg.setup_ok) ctx_nxt.tx_instant = item.now_ms;
            end
            ST_M_PING_DONE: begin
               if (tx_irq) begin
                  inc_tx             = 1'b1;
                  ctx_nxt.tx_instant = item.irq_time_ms;
               end
            end
            ST_M_RX_PONG: begin
               if (item.irq_pending) begin
                  if (item.flag_crc_error) inc_wrong = 1'b1;
                  if (rx_good) begin
                     ctx_nxt.rssi = item.rssi_dbm;
                     if (is_pong) begin
                        inc_ok = 1'b1;
                     end else if (is_ping) begin
                        ctx_nxt.rx_instant = ctx_cur.tx_instant;
                        ctx_nxt.role       = ROLE_SLAVE;
                     end else begin
                        inc_wrong = 1'b1;
                     end
                  end
                  if (item.flag_rx_timeout) inc_to = 2'd1;
               end else if (pong_wait_over) begin
                  inc_to = 2'd1;
               end
            end
            ST_S_RX_PING: begin
               if (item.irq_pending && item.flag_crc_error) inc_wrong = 1'b1;
               if (rx_good) begin
                  ctx_nxt.rssi = item.rssi_dbm;
                  if (is_ping) begin
                     ctx_nxt.rx_instant = item.irq_time_ms;
                     inc_ok             = 1'b1;
                  end else if (is_pong) begin
                     ctx_nxt.tx_instant = item.irq_time_ms;
                     ctx_nxt.role       = ROLE_MASTER;
                  end else begin
                     inc_wrong = 1'b1;
                  end
               end
               // a timeout flag and an expired window may both count
               if (item.irq_pending && item.flag_rx_timeout) begin
                  ctx_nxt.tx_instant = item.irq_time_ms;
                  ctx_nxt.role       = ROLE_MASTER;
                  inc_to             = inc_to + 2'd1;
               end
               if (slave_wait_over) begin
                  ctx_nxt.tx_instant = item.irq_time_ms;
                  ctx_nxt.role       = ROLE_MASTER;
                  inc_to             = inc_to + 2'd1;
               end
            end
            ST_S_PONG_DONE: begin
               if (tx_irq) inc_tx = 1'b1;
            end
            default: inc_tx = 1'b0;
         endcase
      end
      ctx_nxt.state = state_in;
      if (is_stop) begin
         ctx_nxt.tx_cnt    = 32'd0;
         ctx_nxt.ok_cnt    = 32'd0;
         ctx_nxt.wrong_cnt = 32'd0;
         ctx_nxt.to_cnt    = 32'd0;
      end else begin
         ctx_nxt.tx_cnt    = ctx_cur.tx_cnt + {31'd0, inc_tx};
         ctx_nxt.ok_cnt    = ctx_cur.ok_cnt + {31'd0, inc_ok};
         ctx_nxt.wrong_cnt = ctx_cur.wrong_cnt + {31'd0, inc_wrong};
         ctx_nxt.to_cnt    = ctx_cur.to_cnt + {30'd0, inc_to};
      end
   end

endmodule

`default_nettype wire

// ----- design/radio_ping_pong_link_tester_core.sv -----
// ----------------------------------------------------------------------------
// radio_ping_pong_link_tester_core
// ping-pong link-test sequencer for a packet radio
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one poll or stop item per transfer (valid/ready). Each
//    item produces exactly one result transfer on rsp_* (valid/ready) with
//    the radio command, indicator pulse, role, flags and the four counters.
//  - an accepted item waits in the input register; the step logic
//    runs between it and the result register, so rsp_valid rises when
//    the item moves from the input register into the result register.
//  - throughput is one item per cycle: the input register hands its item
//    to the result register whenever that is empty or being taken, and the
//    protocol context is updated at that same edge.
//  - if the receiver stalls, the result register holds and the input
//    register keeps one further item; req_ready drops once both are full.
//  - csr_* writes a configuration register; write it only when no item
//    is in flight.
//  - reset (synchronous) empties both registers, loads the default
//    configuration, puts the protocol in init as master and clears the
//    counters, instants and held rssi.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_ping_pong_link_tester_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // item channel
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic                             req_operation,
   input  wire logic [31:0]                      req_now_ms,
   input  wire logic                             req_irq_pending,
   input  wire logic [31:0]                      req_irq_time_ms,
   input  wire logic                             req_flag_tx_done,
   input  wire logic                             req_flag_rx_done,
   input  wire logic                             req_flag_rx_timeout,
   input  wire logic                             req_flag_crc_error,
   input  wire logic [1:0]                       req_payload_kind,
   input  wire logic signed [7:0]                req_rssi_dbm,
   // result channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [2:0]                       rsp_radio_command,
   output      logic                             rsp_clear_irq,
   output      logic [1:0]                       rsp_indicator,
   output      logic                             rsp_fetch_stats,
   output      logic                             rsp_role,
   output      logic                             rsp_state_changed,
   output      logic                             rsp_error,
   output      logic [31:0]                      rsp_tx_count,
   output      logic [31:0]                      rsp_rx_ok_count,
   output      logic [31:0]                      rsp_rx_wrong_count,
   output      logic [31:0]                      rsp_rx_timeout_count,
   output      logic signed [7:0]                rsp_held_rssi,
   // configuration port
   input  wire logic                             csr_wr_en,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [rpplt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rpplt_pkg::*;

   `include "radio_ping_pong_link_tester_core_assert.svh"

   cfg_type  cfg;
   item_type item_ff;
   logic     in_valid_ff;
   logic     in_valid_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   ctx_type  ctx_ff;
   ctx_type  ctx_in;
   act_type  act_in;
   act_type  act_ff;
   logic     changed_ff;
   logic     out_free;
   logic     advance;
   logic     req_fire;

   rpplt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpplt_step u_step (
      .cfg     (cfg),
      .item    (item_ff),
      .ctx_cur (ctx_ff),
      .ctx_nxt (ctx_in),
      .act     (act_in)
   );

   // transfer control between input and result registers
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || out_free;
   assign req_fire     = req_valid && req_ready;
   assign in_valid_in  = (in_valid_ff && !advance) || req_fire;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.operation       <= req_operation;
         item_ff.now_ms          <= req_now_ms;
         item_ff.irq_pending     <= req_irq_pending;
         item_ff.irq_time_ms     <= req_irq_time_ms;
         item_ff.flag_tx_done    <= req_flag_tx_done;
         item_ff.flag_rx_done    <= req_flag_rx_done;
         item_ff.flag_rx_timeout <= req_flag_rx_timeout;
         item_ff.flag_crc_error  <= req_flag_crc_error;
         item_ff.payload_kind    <= req_payload_kind;
         item_ff.rssi_dbm        <= req_rssi_dbm;
      end
   end

   // protocol context, updated as a step moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state      <= ST_INIT;
         ctx_ff.role       <= ROLE_MASTER;
         ctx_ff.tx_instant <= 32'd0;
         ctx_ff.rx_instant <= 32'd0;
         ctx_ff.tx_cnt     <= 32'd0;
         ctx_ff.ok_cnt     <= 32'd0;
         ctx_ff.wrong_cnt  <= 32'd0;
         ctx_ff.to_cnt     <= 32'd0;
         ctx_ff.rssi       <= 8'sd0;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         act_ff     <= act_in;
         changed_ff <= ctx_in.state != ctx_ff.state;
      end
   end

   // counters, role and rssi come straight from the context
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_radio_command    = act_ff.cmd;
   assign rsp_clear_irq        = act_ff.clear_irq;
   assign rsp_indicator        = act_ff.indicator;
   assign rsp_fetch_stats      = act_ff.fetch_stats;
   assign rsp_role             = ctx_ff.role;
   assign rsp_state_changed    = changed_ff;
   assign rsp_error            = ctx_ff.state == ST_ERROR;
   assign rsp_tx_count         = ctx_ff.tx_cnt;
   assign rsp_rx_ok_count      = ctx_ff.ok_cnt;
   assign rsp_rx_wrong_count   = ctx_ff.wrong_cnt;
   assign rsp_rx_timeout_count = ctx_ff.to_cnt;
   assign rsp_held_rssi        = ctx_ff.rssi;

   // checks
   `RPPLT_ASSERT_NEXT(a_ctx_hold_on_stall, rsp_valid_ff && !rsp_ready, $stable(ctx_ff), "context moved while result stalled")
   `RPPLT_ASSERT_NEXT(a_stop_clears, advance && item_ff.operation == OP_STOP, rsp_radio_command == CMD_STANDBY && rsp_tx_count == 32'd0 && rsp_rx_ok_count == 32'd0 && rsp_rx_wrong_count == 32'd0 && rsp_rx_timeout_count == 32'd0 && ctx_ff.state == ST_INIT, "stop item did not clear counters")
   `RPPLT_ASSERT_NEXT(a_changed_flag, advance, rsp_state_changed == (ctx_ff.state != $past(ctx_ff.state)), "state change flag mismatch")
   `RPPLT_ASSERT_NOW(a_error_sticky, rsp_valid_ff && rsp_error && advance && item_ff.operation == OP_POLL, ctx_in.state == ST_ERROR, "error state left without stop")

endmodule

`default_nettype wire
